@@ hw/rtl/gdasd_pkg.sv @@
// ----------------------------------------------------------------------------
// Date add/subtract package
// Step encoding, microcode table, calendar constants and month length lookup.
// ----------------------------------------------------------------------------
package gdasd_pkg;

    localparam int unsigned YearMin = 1601;
    localparam int unsigned YearMax = 9999;
    localparam int unsigned ModBase = 400;
    localparam int unsigned LeapDay = 29;
    localparam int unsigned NumMonths = 12;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_MOD,
        OP_CHECK,
        OP_BRSUB,
        OP_ADDM,
        OP_SUBM,
        OP_DONE
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE  = 4'd0,
        S_MOD5  = 4'd1,
        S_MOD4  = 4'd2,
        S_MOD3  = 4'd3,
        S_MOD2  = 4'd4,
        S_MOD1  = 4'd5,
        S_MOD0  = 4'd6,
        S_CHECK = 4'd7,
        S_BRSUB = 4'd8,
        S_ADDM  = 4'd9,
        S_SUBM  = 4'd10,
        S_DONE  = 4'd11
    } t_step;

    typedef struct packed {
        t_op        op;
        logic [2:0] shamt;
        t_step      next_t;
        t_step      next_f;
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '{op: OP_IDLE, shamt: 3'd0, next_t: S_IDLE, next_f: S_IDLE};
        case (s)
            S_IDLE:  w = '{op: OP_IDLE,  shamt: 3'd0, next_t: S_MOD5,  next_f: S_IDLE};
            S_MOD5:  w = '{op: OP_MOD,   shamt: 3'd5, next_t: S_MOD4,  next_f: S_MOD4};
            S_MOD4:  w = '{op: OP_MOD,   shamt: 3'd4, next_t: S_MOD3,  next_f: S_MOD3};
            S_MOD3:  w = '{op: OP_MOD,   shamt: 3'd3, next_t: S_MOD2,  next_f: S_MOD2};
            S_MOD2:  w = '{op: OP_MOD,   shamt: 3'd2, next_t: S_MOD1,  next_f: S_MOD1};
            S_MOD1:  w = '{op: OP_MOD,   shamt: 3'd1, next_t: S_MOD0,  next_f: S_MOD0};
            S_MOD0:  w = '{op: OP_MOD,   shamt: 3'd0, next_t: S_CHECK, next_f: S_CHECK};
            S_CHECK: w = '{op: OP_CHECK, shamt: 3'd0, next_t: S_DONE,  next_f: S_BRSUB};
            S_BRSUB: w = '{op: OP_BRSUB, shamt: 3'd0, next_t: S_SUBM,  next_f: S_ADDM};
            S_ADDM:  w = '{op: OP_ADDM,  shamt: 3'd0, next_t: S_ADDM,  next_f: S_DONE};
            S_SUBM:  w = '{op: OP_SUBM,  shamt: 3'd0, next_t: S_SUBM,  next_f: S_DONE};
            S_DONE:  w = '{op: OP_DONE,  shamt: 3'd0, next_t: S_IDLE,  next_f: S_IDLE};
            default: w = '{op: OP_IDLE,  shamt: 3'd0, next_t: S_IDLE,  next_f: S_IDLE};
        endcase
        return w;
    endfunction

    // residue is year mod 400
    function automatic logic is_leap(input logic [8:0] r);
        return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd0;
        case (m) inside
            4'd2:                                    len = leap ? 5'(LeapDay) : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                 len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            default:                                 len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/gregorian_date_add_sub_days.sv @@
// Steps: year mod 400 residue, start date check, a branch on the request type, then one month step
// per month moved over; an invalid start date goes from the check straight to the result strobe.
// Throughput: one request at a time; busy stays high until the result strobe.
// The month step loop of the sequencer sets how long a request runs.
// Reset: synchronous, active low; returns the sequencer to idle, drops the strobe.
// ----------------------------------------------------------------------------
// Gregorian date add/subtract days
// Microcoded sequencer that walks month by month to add or subtract a day
// count from a date, with validity and year range checks.
// ----------------------------------------------------------------------------
module gregorian_date_add_sub_days (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [4:0]  i_in_day,
    input  logic [3:0]  i_in_month,
    input  logic [13:0] i_in_year,
    input  logic [15:0] i_day_count,
    output logic        o_valid,
    output logic [4:0]  o_out_day,
    output logic [3:0]  o_out_month,
    output logic [13:0] o_out_year,
    output logic [1:0]  o_status
);
    import gdasd_pkg::*;

    t_step              r_pc, n_pc;
    logic signed [17:0] r_day, n_day;
    logic [3:0]         r_month, n_month;
    logic [14:0]        r_year, n_year;
    logic [14:0]        r_rem, n_rem;
    logic [15:0]        r_count, n_count;
    logic               r_sub, n_sub;
    t_status            r_status, n_status;
    logic               r_valid, n_valid;
    logic [4:0]         r_out_day, n_out_day;
    logic [3:0]         r_out_month, n_out_month;
    logic [13:0]        r_out_year, n_out_year;
    logic [1:0]         r_out_status, n_out_status;

    t_uword             cw;
    logic               cond;
    logic               leap;
    logic [3:0]         prev_m;
    logic [4:0]         len_cur;
    logic [4:0]         len_prev;
    logic [14:0]        mod_sub;
    logic               invalid;
    logic               out_of_range;

    assign leap     = is_leap(r_rem[8:0]);
    assign prev_m   = (r_month == 4'd1) ? 4'(NumMonths) : r_month - 4'd1;
    assign len_cur  = month_len(r_month, leap);
    assign len_prev = month_len(prev_m, leap);
    assign mod_sub  = 15'(ModBase) << cw.shamt;
    assign invalid  = (r_year < 15'(YearMin)) || (r_month == 4'd0)
                   || (r_month > 4'(NumMonths)) || (r_day < 18'sd1)
                   || (r_day > $signed({13'd0, len_cur}));
    assign out_of_range = (r_year < 15'(YearMin)) || (r_year > 15'(YearMax));

    always_comb begin
        cw           = ucode(r_pc);
        cond         = 1'b0;
        n_day        = r_day;
        n_month      = r_month;
        n_year       = r_year;
        n_rem        = r_rem;
        n_count      = r_count;
        n_sub        = r_sub;
        n_status     = r_status;
        n_valid      = 1'b0;
        n_out_day    = r_out_day;
        n_out_month  = r_out_month;
        n_out_year   = r_out_year;
        n_out_status = r_out_status;
        case (cw.op)
            OP_IDLE: begin
                cond = start;
                if (start) begin
                    n_day    = $signed({13'd0, i_in_day});
                    n_month  = i_in_month;
                    n_year   = {1'b0, i_in_year};
                    n_rem    = {1'b0, i_in_year};
                    n_count  = i_day_count;
                    n_sub    = i_req_type;
                    n_status = ST_OK;
                end
            end
            OP_MOD: begin
                cond = r_rem >= mod_sub;
                if (cond) begin
                    n_rem = r_rem - mod_sub;
                end
            end
            OP_CHECK: begin
                cond = invalid;
                if (invalid) begin
                    n_status = ST_BAD_DATE;
                end else if (r_sub) begin
                    n_day = r_day - $signed({2'd0, r_count});
                end else begin
                    n_day = r_day + $signed({2'd0, r_count});
                end
            end
            OP_BRSUB: begin
                cond = r_sub;
            end
            OP_ADDM: begin
                cond = r_day > $signed({13'd0, len_cur});
                if (cond) begin
                    n_day = r_day - $signed({13'd0, len_cur});
                    if (r_month >= 4'(NumMonths)) begin
                        n_month = 4'd1;
                        n_year  = r_year + 15'd1;
                        n_rem   = (r_rem == 15'(ModBase - 1)) ? 15'd0 : r_rem + 15'd1;
                    end else begin
                        n_month = r_month + 4'd1;
                    end
                end
            end
            OP_SUBM: begin
                cond = r_day < 18'sd1;
                if (cond) begin
                    n_day   = r_day + $signed({13'd0, len_prev});
                    n_month = prev_m;
                    if (r_month == 4'd1) begin
                        n_year = r_year - 15'd1;
                        n_rem  = (r_rem == 15'd0) ? 15'(ModBase - 1) : r_rem - 15'd1;
                    end
                end
            end
            OP_DONE: begin
                n_valid = 1'b1;
                if (r_status != ST_OK) begin
                    n_out_status = r_status;
                end else if (out_of_range) begin
                    n_out_status = ST_RANGE;
                end else begin
                    n_out_status = ST_OK;
                end
                if (r_status == ST_OK && !out_of_range) begin
                    n_out_day   = r_day[4:0];
                    n_out_month = r_month;
                    n_out_year  = r_year[13:0];
                end else begin
                    n_out_day   = 5'd0;
                    n_out_month = 4'd0;
                    n_out_year  = 14'd0;
                end
            end
            default: begin
                cond = 1'b0;
            end
        endcase
        n_pc = cond ? cw.next_t : cw.next_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_valid <= n_valid;
        end
        r_day        <= n_day;
        r_month      <= n_month;
        r_year       <= n_year;
        r_rem        <= n_rem;
        r_count      <= n_count;
        r_sub        <= n_sub;
        r_status     <= n_status;
        r_out_day    <= n_out_day;
        r_out_month  <= n_out_month;
        r_out_year   <= n_out_year;
        r_out_status <= n_out_status;
    end

    assign busy        = (r_pc != S_IDLE);
    assign o_valid     = r_valid;
    assign o_out_day   = r_out_day;
    assign o_out_month = r_out_month;
    assign o_out_year  = r_out_year;
    assign o_status    = r_out_status;

`ifndef ASSERT_OFF
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but sequencer not busy");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_pc) == S_DONE) && !busy)
        else $error("result strobe outside the final step");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
            (o_out_day == 5'd0 && o_out_month == 4'd0 && o_out_year == 14'd0))
        else $error("error result with non-zero date");

    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |->
            (o_out_day != 5'd0 && o_out_month != 4'd0 && o_out_month <= 4'(NumMonths)))
        else $error("ok result with malformed date");
`endif

endmodule
